// File: src/bet_pkg.sv
// ----------------------------------------------------------------------------
// bet_pkg
// Shared types and constants for the push-button event tracker.
// ----------------------------------------------------------------------------
package bet_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int PIN_W       = 8;
  localparam int IDX_W       = 3;
  localparam int HOLD_W      = 32;
  localparam int MASK_W      = 8;

  localparam logic [HOLD_W-1:0] HOLD_STEP = HOLD_W'(10);
  localparam logic [HOLD_W-1:0] HOLD_MAX  = {HOLD_W{1'b1}};
  localparam logic [MASK_W-1:0] MASK_RESET = {MASK_W{1'b1}};

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_Q_PUSHED   = 3'd1,
    OP_Q_RELEASED = 3'd2,
    OP_Q_HELD     = 3'd3,
    OP_CLEAR      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PH_CLEARED  = 2'd0,
    PH_READY    = 2'd1,
    PH_PUSHED   = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  // command broadcast from the item register to every button
  typedef struct packed {
    logic              go;
    op_t               op;
    logic [HOLD_W-1:0] threshold;
  } btn_cmd_t;

endpackage

// File: src/bet_button.sv
// ----------------------------------------------------------------------------
// bet_button
// State of one button: phase, pushed and released flags, hold time.
// ----------------------------------------------------------------------------
module bet_button (
  input  logic             clk,
  input  logic             rst,
  input  bet_pkg::btn_cmd_t cmd,
  input  logic             sel,
  input  logic             pin,
  input  logic             en,
  output logic             hit
);
  import bet_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic              pushed_flag;
  logic              pushed_flag_next;
  logic              released_flag;
  logic              released_flag_next;
  logic [HOLD_W-1:0] hold_time;
  logic [HOLD_W-1:0] hold_time_next;
  logic [HOLD_W:0]   hold_sum;
  logic              cond;

  assign hold_sum = {1'b0, hold_time} + {1'b0, HOLD_STEP};

  always_comb begin
    case (cmd.op)
      OP_Q_PUSHED:   cond = pushed_flag;
      OP_Q_RELEASED: cond = released_flag;
      OP_Q_HELD:     cond = (hold_time > cmd.threshold);
      default:       cond = 1'b0;
    endcase
  end

  assign hit = sel & cond;

  always_comb begin
    phase_next         = phase;
    pushed_flag_next   = pushed_flag;
    released_flag_next = released_flag;
    hold_time_next     = hold_time;
    if (cmd.op == OP_TICK) begin
      if (en) begin
        case (phase)
          PH_CLEARED: begin
            if (pin) phase_next = PH_READY;
          end
          PH_READY: begin
            if (!pin) begin
              phase_next       = PH_PUSHED;
              pushed_flag_next = 1'b1;
            end
          end
          PH_PUSHED: begin
            if (pin) begin
              phase_next         = PH_RELEASED;
              released_flag_next = 1'b1;
            end else if (hold_sum[HOLD_W]) begin
              hold_time_next = HOLD_MAX;
            end else begin
              hold_time_next = hold_sum[HOLD_W-1:0];
            end
          end
          default: begin
            if (!pin) begin
              phase_next         = PH_PUSHED;
              released_flag_next = 1'b0;
              hold_time_next     = '0;
            end
          end
        endcase
      end
    end else if (cmd.op == OP_CLEAR || hit) begin
      phase_next         = PH_CLEARED;
      pushed_flag_next   = 1'b0;
      released_flag_next = 1'b0;
      hold_time_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CLEARED;
      pushed_flag   <= 1'b0;
      released_flag <= 1'b0;
      hold_time     <= '0;
    end else if (cmd.go) begin
      phase         <= phase_next;
      pushed_flag   <= pushed_flag_next;
      released_flag <= released_flag_next;
      hold_time     <= hold_time_next;
    end
  end

endmodule

// File: src/button_event_tracker_top.sv
// ----------------------------------------------------------------------------
// button_event_tracker_top
// Press, release and hold detector for a bank of active-low push buttons.
// ----------------------------------------------------------------------------
// One item per clock: an accepted item lands in an input register, all buttons
// update in parallel from it when it moves on to the output, and the one-bit
// answer is registered at the output as the result; a new item can be taken
// every cycle while the output is drained.
// The limit is the single per-button update plus the 32-bit hold compare
// between the two registers.
// enable_mask is written through cfg_we / cfg_wdata and resets to all ones.
module button_event_tracker_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bet_pkg::MASK_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                op,
  input  logic [bet_pkg::IDX_W-1:0] button_index,
  input  logic [bet_pkg::PIN_W-1:0] pin_levels,
  input  logic [bet_pkg::HOLD_W-1:0] hold_threshold,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit
);
  import bet_pkg::*;

  logic [MASK_W-1:0] enable_mask;
  logic              item_valid;
  op_t               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PIN_W-1:0]  pins_q;
  logic [HOLD_W-1:0] thr_q;
  logic              advance;
  btn_cmd_t          cmd;
  logic [NUM_BUTTONS-1:0] btn_hit;

  assign advance  = item_valid & (~out_valid | out_ready);
  assign in_ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= MASK_RESET;
    end else if (cfg_we) begin
      enable_mask <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op_t'(op);
      idx_q  <= button_index;
      pins_q <= pin_levels;
      thr_q  <= hold_threshold;
    end
  end

  assign cmd.go        = advance;
  assign cmd.op        = op_q;
  assign cmd.threshold = thr_q;

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_btn
    logic pin_k;
    logic en_k;
    // buttons past the pin word see a low pin and no enable
    if (k < PIN_W) begin : g_pin
      assign pin_k = pins_q[k];
      assign en_k  = enable_mask[k];
    end else begin : g_nopin
      assign pin_k = 1'b0;
      assign en_k  = 1'b0;
    end

    bet_button u_button (
      .clk (clk),
      .rst (rst),
      .cmd (cmd),
      .sel (int'(idx_q) == k),
      .pin (pin_k),
      .en  (en_k),
      .hit (btn_hit[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit <= |btn_hit;
    end
  end

endmodule
